// File: rtl/mpst_pkg.sv
// ----------------------------------------------------------------------------
// mpst_pkg
// Shared types, sizes and helper functions for the min-plus pattern cost core.
// ----------------------------------------------------------------------------
package mpst_pkg;

    localparam int LEAVES    = 1024;
    localparam int LEAF_LOG  = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int LEAF_BASE = 1 << LEAF_LOG;
    localparam int ADDR_W    = LEAF_LOG + 1;
    localparam int NODES     = 2 * LEAF_BASE;

    localparam int POS_W     = 10;
    localparam int SYM_W     = 2;
    localparam int COST_W    = 11;
    localparam int ENTRIES   = 6;
    localparam int STEP_W    = 3;

    typedef logic [POS_W-1:0]                t_pos;
    typedef logic [SYM_W-1:0]                t_sym;
    typedef logic [COST_W-1:0]               t_cost;
    typedef logic [ADDR_W-1:0]               t_addr;
    typedef logic [STEP_W-1:0]               t_step;
    typedef logic [ENTRIES-1:0][COST_W-1:0]  t_mat;

    // Slots of the upper-triangular matrix inside one node word.
    localparam t_step E_00 = 3'd0;
    localparam t_step E_11 = 3'd1;
    localparam t_step E_22 = 3'd2;
    localparam t_step E_01 = 3'd3;
    localparam t_step E_12 = 3'd4;
    localparam t_step E_02 = 3'd5;

    localparam t_sym SYM_NONE = 2'd3;

    function automatic t_mat leaf_mat(t_sym sym);
        t_mat m;
        m = '0;
        if (sym != SYM_NONE) begin
            m[sym] = t_cost'(1);
        end
        return m;
    endfunction

    function automatic t_cost min3(logic [COST_W:0] a, logic [COST_W:0] b,
                                   logic [COST_W:0] c);
        logic [COST_W:0] m;
        m = (b < a) ? b : a;
        m = (c < m) ? c : m;
        return m[COST_W-1:0];
    endfunction

    // One entry of the min-plus product of left and right children.
    function automatic t_cost merge_entry(t_mat l, t_mat r, t_step e);
        logic [COST_W-1:0] a0, b0, a1, b1, a2, b2;
        a0 = l[E_00]; b0 = r[E_00];
        a1 = a0;      b1 = b0;
        a2 = a0;      b2 = b0;
        unique case (e)
            E_00: begin
                a0 = l[E_00]; b0 = r[E_00];
                a1 = a0; b1 = b0; a2 = a0; b2 = b0;
            end
            E_11: begin
                a0 = l[E_11]; b0 = r[E_11];
                a1 = a0; b1 = b0; a2 = a0; b2 = b0;
            end
            E_22: begin
                a0 = l[E_22]; b0 = r[E_22];
                a1 = a0; b1 = b0; a2 = a0; b2 = b0;
            end
            E_01: begin
                a0 = l[E_00]; b0 = r[E_01];
                a1 = l[E_01]; b1 = r[E_11];
                a2 = a1;      b2 = b1;
            end
            E_12: begin
                a0 = l[E_11]; b0 = r[E_12];
                a1 = l[E_12]; b1 = r[E_22];
                a2 = a1;      b2 = b1;
            end
            E_02: begin
                a0 = l[E_00]; b0 = r[E_02];
                a1 = l[E_01]; b1 = r[E_12];
                a2 = l[E_02]; b2 = r[E_22];
            end
            default: begin
                a0 = '0; b0 = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0;
            end
        endcase
        return min3({1'b0, a0} + {1'b0, b0}, {1'b0, a1} + {1'b0, b1},
                    {1'b0, a2} + {1'b0, b2});
    endfunction

endpackage

// File: rtl/mpst_req_if.sv
// ----------------------------------------------------------------------------
// mpst_req_if
// Request channel: leaf position and new symbol, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpst_req_if;
    logic          valid;
    logic          ready;
    mpst_pkg::t_pos position;
    mpst_pkg::t_sym symbol;

    modport source (output valid, output position, output symbol, input ready);
    modport sink   (input valid, input position, input symbol, output ready);
endinterface

// File: rtl/mpst_rsp_if.sv
// ----------------------------------------------------------------------------
// mpst_rsp_if
// Response channel: pattern cost of the whole string, with valid/ready.
// ----------------------------------------------------------------------------
interface mpst_rsp_if;
    logic            valid;
    logic            ready;
    mpst_pkg::t_cost cost;

    modport source (output valid, output cost, input ready);
    modport sink   (input valid, input cost, output ready);
endinterface

// File: rtl/minplus_segment_tree_pattern_cost_core.sv
// ----------------------------------------------------------------------------
// minplus_segment_tree_pattern_cost_core
// Segment tree of 3x3 min-plus cost matrices over a string of 3-letter symbols.
// ----------------------------------------------------------------------------
// After reset the core sweeps its node memory to zero, one node per cycle,
// over all 2048 nodes, and takes no request until that pass ends. Each
// request writes one leaf as it is taken and then walks the ten levels to the
// root; each level is one sibling read from the node memory and six steps of
// the shared merge unit, which forms one matrix entry per step and writes the
// parent on the last one. The result is shown once the root is written, and
// the next request is taken once the result leaves.
module minplus_segment_tree_pattern_cost_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpst_req_if.sink   i_req,
    mpst_rsp_if.source o_rsp
);
    import mpst_pkg::*;

    typedef enum logic [4:0] {
        ST_CLR  = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_RD   = 5'b00100,
        ST_MG   = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_addr  r_clr, n_clr;
    t_addr  r_node, n_node;
    t_step  r_step, n_step;
    t_mat   r_cur, n_cur;
    t_mat   r_acc, n_acc;
    t_cost  r_cost, n_cost;
    t_mat   r_rd;

    t_mat   r_mem [NODES];

    logic   wr_en;
    t_addr  wr_addr;
    t_mat   wr_data;
    logic   rd_en;
    t_addr  rd_addr;
    t_addr  parent;
    t_mat   left_m;
    t_mat   right_m;
    t_cost  entry;

    assign parent  = {1'b0, r_node[ADDR_W-1:1]};
    assign left_m  = r_node[0] ? r_rd  : r_cur;
    assign right_m = r_node[0] ? r_cur : r_rd;
    assign entry   = merge_entry(left_m, right_m, r_step);

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = (r_state == ST_OUT);
    assign o_rsp.cost  = r_cost;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_node  = r_node;
        n_step  = r_step;
        n_cur   = r_cur;
        n_acc   = r_acc;
        n_cost  = r_cost;
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = r_node ^ t_addr'(1);
        unique case (r_state)
            ST_CLR: begin
                wr_en = 1'b1;
                n_clr = r_clr + t_addr'(1);
                if (r_clr == t_addr'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    if ({1'b0, i_req.position} < (POS_W + 1)'(LEAVES)) begin
                        wr_en   = 1'b1;
                        wr_addr = t_addr'(LEAF_BASE) + t_addr'(i_req.position);
                        wr_data = leaf_mat(i_req.symbol);
                        n_node  = wr_addr;
                        n_cur   = wr_data;
                        n_state = ST_RD;
                    end else begin
                        n_cost  = r_cost;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                n_step  = '0;
                n_state = ST_MG;
            end
            ST_MG: begin
                n_acc[r_step] = entry;
                n_step        = r_step + t_step'(1);
                if (r_step == E_02) begin
                    wr_en   = 1'b1;
                    wr_addr = parent;
                    wr_data = n_acc;
                    n_cur   = n_acc;
                    n_node  = parent;
                    if (parent == t_addr'(1)) begin
                        n_cost  = n_acc[E_02];
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_OUT: begin
                if (o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_cost  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cost  <= n_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_step <= n_step;
        r_cur  <= n_cur;
        r_acc  <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

endmodule

// File: tb/sv/minplus_segment_tree_pattern_cost_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minplus_segment_tree_pattern_cost_core_test
// Writes symbols into the pattern cost tree through the request channel and
// checks every reported cost against a behavioral copy of the min-plus tree.
// Directed writes cover the string ends, cleared leaves and small patterns.
// Random writes then favor ordered strings that drive the cost up.
// ----------------------------------------------------------------------------
module minplus_segment_tree_pattern_cost_core_test;

    import mpst_pkg::*;

    localparam t_sym SYM_A      = 2'd0;
    localparam t_sym SYM_B      = 2'd1;
    localparam t_sym SYM_C      = 2'd2;
    localparam int   N_RANDOM   = 1530;
    localparam int   HOLD_LEN   = 400;
    localparam int   MAX_REPORT = 10;

    typedef struct {
        t_pos pos;
        t_sym sym;
        bit   drain_first;
    } t_leaf_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpst_req_if req_if();
    mpst_rsp_if rsp_if();

    minplus_segment_tree_pattern_cost_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    t_leaf_write write_q[$];
    t_leaf_write cur_write;
    t_cost       cost_q[$];
    int          node_cost[NODES][3][3];
    int          total_writes;
    int          acc_count;
    int          got_count;
    int          err_count;
    int          hold_left;
    int          holds_used;

    always #6 i_clk = ~i_clk;

    function automatic int idle_phase();
        return (acc_count * 3) / total_writes;
    endfunction

    function automatic int send_idle_pct();
        return (idle_phase() == 0) ? 8 : (idle_phase() == 1) ? 51 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (idle_phase() == 0) ? 51 : (idle_phase() == 1) ? 8 : 0;
    endfunction

    // Writes one leaf of the tree copy, re-merges the path to the root and
    // returns the root cost of the pattern 0,1,2.
    function automatic t_cost tree_write_cost(t_pos pos, t_sym sym);
        int n;
        int lc;
        int best;
        int sum;
        n = LEAF_BASE + int'(pos);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                node_cost[n][i][j] = 0;
            end
        end
        if (sym != SYM_NONE) begin
            node_cost[n][sym][sym] = 1;
        end
        for (n = n >> 1; n != 0; n = n >> 1) begin
            lc = 2 * n;
            for (int i = 0; i < 3; i++) begin
                for (int j = i; j < 3; j++) begin
                    best = node_cost[lc][i][i] + node_cost[lc + 1][i][j];
                    for (int k = i + 1; k <= j; k++) begin
                        sum = node_cost[lc][i][k] + node_cost[lc + 1][k][j];
                        if (sum < best) begin
                            best = sum;
                        end
                    end
                    node_cost[n][i][j] = best;
                end
            end
        end
        return t_cost'(node_cost[1][0][2]);
    endfunction

    task automatic add_write(input t_pos pos, input t_sym sym, input bit drain_first);
        t_leaf_write w;
        w.pos         = pos;
        w.sym         = sym;
        w.drain_first = drain_first;
        write_q.insert(write_q.size(), w);
    endtask

    task automatic report(input string msg);
        if (err_count < MAX_REPORT) begin
            $display("%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    always @(posedge i_clk) begin
        bit took;
        bit drained;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            acc_count    <= 0;
        end else begin
            took = req_if.valid && req_if.ready;
            if (took) begin
                cost_q.insert(cost_q.size(), tree_write_cost(cur_write.pos, cur_write.sym));
                acc_count <= acc_count + 1;
            end
            drained = !took && (acc_count == got_count);
            if (!req_if.valid || took) begin
                if (write_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()
                    && (!write_q[0].drain_first || drained)) begin
                    cur_write       = write_q.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.position <= cur_write.pos;
                    req_if.symbol   <= cur_write.sym;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_cost want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            got_count    <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_count <= got_count + 1;
                if (cost_q.size() == 0) begin
                    report($sformatf("unrequested cost %0d", rsp_if.cost));
                end else begin
                    want = cost_q.pop_front();
                    if (rsp_if.cost !== want) begin
                        report($sformatf("cost mismatch on result %0d: expected %0d, got %0d",
                                         got_count, want, rsp_if.cost));
                    end
                end
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_used <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_used < 2 && acc_count == ((holds_used == 0) ? 40 : 900)) begin
            hold_left  <= HOLD_LEN;
            holds_used <= holds_used + 1;
        end
    end

    initial begin
        #(8_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_pos pos;
        t_sym sym;
        int   roll;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.position = '0;
        req_if.symbol   = '0;
        rsp_if.ready    = 1'b0;
        err_count       = 0;
        for (int n = 0; n < NODES; n++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    node_cost[n][i][j] = 0;
                end
            end
        end

        add_write(10'd0,    SYM_A,    1'b0);
        add_write(10'd1023, SYM_C,    1'b0);
        add_write(10'd512,  SYM_B,    1'b0);
        add_write(10'd1023, SYM_NONE, 1'b0);
        add_write(10'd1023, SYM_C,    1'b0);
        add_write(10'd0,    SYM_C,    1'b0);
        add_write(10'd0,    SYM_A,    1'b0);
        add_write(10'd1,    SYM_A,    1'b0);
        add_write(10'd511,  SYM_B,    1'b0);
        add_write(10'd1022, SYM_C,    1'b0);
        add_write(10'd512,  SYM_B,    1'b0);
        add_write(10'd341,  SYM_B,    1'b0);
        add_write(10'd682,  SYM_B,    1'b0);
        add_write(10'd513,  SYM_A,    1'b0);
        add_write(10'd514,  SYM_C,    1'b0);
        add_write(10'd0,    SYM_NONE, 1'b0);
        add_write(10'd512,  SYM_NONE, 1'b0);
        add_write(10'd2,    SYM_NONE, 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            pos  = t_pos'($urandom_range(0, LEAVES - 1));
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                sym = t_sym'((int'(pos) * 3) / LEAVES);
            end else if (roll < 92) begin
                sym = t_sym'($urandom_range(0, 2));
            end else begin
                sym = t_sym'($urandom_range(0, 3));
            end
            add_write(pos, sym, (n % 500) == 0);
        end
        total_writes = write_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (acc_count != total_writes || got_count != acc_count) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);

        if (err_count == 0 && cost_q.size() == 0 && got_count == acc_count) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
